FILE: hw/rtl/apq_pkg.sv
// ----------------------------------------------------------------------------
// apq_pkg
// Shared sizes, operation and status codes, and the command and status
// bundles that run between the priority queue controller and its datapath.
// ----------------------------------------------------------------------------
package apq_pkg;

  localparam int DEPTH  = 256;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = IDX_W + 1;
  localparam int DATA_W = 32;
  localparam int ENTRY_W = 2 * DATA_W;

  localparam int IN_TDATA_W  = 2 * DATA_W;
  localparam int OUT_FIELD_W = 2 * DATA_W + CNT_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  typedef enum logic [1:0] {
    FN_ENQ  = 2'd0,
    FN_DEQ  = 2'd1,
    FN_PEEK = 2'd2,
    FN_NOP  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    capture;      // latch the input beat
    logic    enq_write;    // append the latched entry, bump the count
    logic    set_res;      // load the result with res_status and zero payload
    status_t res_status;
    logic    scan_start;   // sweep all entries looking for the winner
    logic    res_best;     // load the result from the winner
    logic    shift_start;  // sweep the entries above the winner down by one
    logic    dec_count;    // drop the count after a dequeue
    logic    load_out;     // move the result into the output register
  } apq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    func_t func;
    logic  cnt_zero;
    logic  cnt_full;
    logic  sweep_busy;
  } apq_sts_t;

endpackage

FILE: hw/rtl/apq_ctrl.sv
// ----------------------------------------------------------------------------
// apq_ctrl
// Sequencer for the priority queue: decodes each operation, runs the scan
// and shift sweeps in the datapath and hands the result to the output stage.
// ----------------------------------------------------------------------------
module apq_ctrl
  import apq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  apq_sts_t sts,
  output apq_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_PICK,
    S_SHIFT,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.res_status = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.func)
          FN_ENQ: begin
            cmd.set_res = 1'b1;
            if (sts.cnt_full) begin
              cmd.res_status = ST_FULL;
            end else begin
              cmd.enq_write = 1'b1;
            end
            state_nxt = S_FINISH;
          end
          FN_DEQ, FN_PEEK: begin
            if (sts.cnt_zero) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = ST_EMPTY;
              state_nxt      = S_FINISH;
            end else begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN;
            end
          end
          default: begin
            cmd.set_res = 1'b1;
            state_nxt   = S_FINISH;
          end
        endcase
      end
      S_SCAN: begin
        if (!sts.sweep_busy) begin
          state_nxt = S_PICK;
        end
      end
      S_PICK: begin
        cmd.res_best = 1'b1;
        if (sts.func == FN_DEQ) begin
          cmd.shift_start = 1'b1;
          state_nxt       = S_SHIFT;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_SHIFT: begin
        if (!sts.sweep_busy) begin
          cmd.dec_count = 1'b1;
          state_nxt     = S_FINISH;
        end
      end
      S_FINISH: begin
        // The output register may still hold the previous beat.
        if (!out_valid_r || out_tready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_tready))
    else $error("result loaded over an untaken beat");

  a_shift_deq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> (sts.func == FN_DEQ))
    else $error("shift sweep outside a dequeue");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_start |-> !sts.cnt_zero)
    else $error("scan started on an empty queue");
`endif

endmodule

FILE: hw/rtl/apq_dp.sv
// ----------------------------------------------------------------------------
// apq_dp
// Datapath of the priority queue: entry memory, entry count, the sweep
// pointer shared by the scan and the shift, the winner registers and the
// result and output registers.
// ----------------------------------------------------------------------------
module apq_dp
  import apq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [1:0]             in_tuser,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic [1:0]             out_tuser,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  apq_cmd_t               cmd,
  output apq_sts_t               sts
);

  // Each entry holds the priority in the upper half and the value below it.
  logic [ENTRY_W-1:0] mem [DEPTH];

  func_t              func_r;
  logic [DATA_W-1:0]  val_r;
  logic [DATA_W-1:0]  pri_r;
  logic [CNT_W-1:0]   count_r;

  logic               active_r;
  logic               scan_mode_r;
  logic [CNT_W-1:0]   ptr_r;
  logic               rvalid_r;
  logic [IDX_W-1:0]   rd_idx_r;
  logic [ENTRY_W-1:0] rdata_r;

  logic [ENTRY_W-1:0] best_r;
  logic [IDX_W-1:0]   best_idx_r;

  status_t            res_status_r;
  logic [ENTRY_W-1:0] res_entry_r;
  logic [1:0]         out_tuser_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  logic               issue;
  logic               better;
  logic [IDX_W-1:0]   wr_idx;

  assign issue  = active_r && (ptr_r < count_r);
  assign wr_idx = rd_idx_r - IDX_W'(1);

  // Higher priority wins, then the larger value; a full tie keeps the older.
  always_comb begin
    logic signed [DATA_W-1:0] rp, bp, rv, bv;
    rp = $signed(rdata_r[ENTRY_W-1:DATA_W]);
    bp = $signed(best_r[ENTRY_W-1:DATA_W]);
    rv = $signed(rdata_r[DATA_W-1:0]);
    bv = $signed(best_r[DATA_W-1:0]);
    better = (rp > bp) || ((rp == bp) && (rv > bv));
  end

  assign sts.func       = func_r;
  assign sts.cnt_zero   = (count_r == '0);
  assign sts.cnt_full   = (count_r == CNT_W'(DEPTH));
  assign sts.sweep_busy = issue || rvalid_r;

  always_ff @(posedge clk) begin
    if (cmd.enq_write) begin
      mem[count_r[IDX_W-1:0]] <= {pri_r, val_r};
    end else if (rvalid_r && !scan_mode_r) begin
      mem[wr_idx] <= rdata_r;
    end
    if (issue) begin
      rdata_r <= mem[ptr_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      active_r <= 1'b0;
      rvalid_r <= 1'b0;
    end else begin
      if (cmd.enq_write) begin
        count_r <= count_r + CNT_W'(1);
      end else if (cmd.dec_count) begin
        count_r <= count_r - CNT_W'(1);
      end
      if (cmd.scan_start || cmd.shift_start) begin
        active_r <= 1'b1;
      end else if (!issue) begin
        active_r <= 1'b0;
      end
      rvalid_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= func_t'(in_tuser);
      val_r  <= in_tdata[DATA_W-1:0];
      pri_r  <= in_tdata[IN_TDATA_W-1:DATA_W];
    end
    if (cmd.scan_start) begin
      ptr_r       <= '0;
      scan_mode_r <= 1'b1;
    end else if (cmd.shift_start) begin
      ptr_r       <= {1'b0, best_idx_r} + CNT_W'(1);
      scan_mode_r <= 1'b0;
    end else if (issue) begin
      ptr_r <= ptr_r + CNT_W'(1);
    end
    rd_idx_r <= ptr_r[IDX_W-1:0];
    if (rvalid_r && scan_mode_r && ((rd_idx_r == '0) || better)) begin
      best_r     <= rdata_r;
      best_idx_r <= rd_idx_r;
    end
    if (cmd.set_res) begin
      res_status_r <= cmd.res_status;
      res_entry_r  <= '0;
    end else if (cmd.res_best) begin
      res_status_r <= ST_OK;
      res_entry_r  <= best_r;
    end
    if (cmd.load_out) begin
      out_tuser_r <= res_status_r;
      out_tdata_r <= {{OUT_PAD_W{1'b0}}, count_r, res_entry_r};
    end
  end

  assign out_tuser = out_tuser_r;
  assign out_tdata = out_tdata_r;

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_dec_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.dec_count |-> (count_r != '0) && !sts.sweep_busy)
    else $error("count dropped on empty queue or during a sweep");

  a_enq_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.enq_write |-> !sts.cnt_full && !rvalid_r)
    else $error("append with no room or during a shift");
`endif

endmodule

FILE: hw/rtl/array_priority_queue_core.sv
// ----------------------------------------------------------------------------
// array_priority_queue_core
// Priority queue over an unsorted array kept in insertion order. Enqueue
// appends, dequeue removes the best entry and closes the gap, peek reads it.
//
//   channel  dir  tdata fields (low bit up)                tuser
//   in_      in   value_in[31:0] priority_in[63:32]        func
//   out_     out  value_out[31:0] priority_out[63:32]      status
//                 count_out[72:64], zero pad[79:73]
//
// Enqueue, full, empty and the unused code go from decode straight to the
// finish state and the output register. Peek scans all stored entries for
// the winner; dequeue scans, then moves the entries above it down by one.
// The single read port of the memory sets both sweeps at one entry per cycle.
// Reset clears count and control state; the entry memory needs no clearing pass.
// One operation is in flight at a time; a new beat is taken while a result
// still waits in the output register, and a stall holds only the last stage.
// ----------------------------------------------------------------------------
module array_priority_queue_core
  import apq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // value_in, priority_in
  input  logic [1:0]             in_tuser,   // func
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // value_out, priority_out, count_out
  output logic [1:0]             out_tuser   // status
);

  apq_cmd_t cmd;
  apq_sts_t sts;

  apq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  apq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tuser (out_tuser),
    .out_tdata (out_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
